// File: design/hrfd_pkg.sv
package hrfd_pkg;

  // Field and register widths.
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 24;
  localparam int STAT_W = 2;

  // Reset value of the NAL capacity register.
  localparam logic [CFG_W-1:0] MAX_NAL_RESET = 24'h100000;

  // NAL unit type of a fragmentation unit.
  localparam logic [5:0] FU_TYPE = 6'd49;

  // Start code plus rebuilt two-byte NAL header.
  localparam int HDR_BURST     = 6;
  localparam int HDR_NAL_BYTES = 6;

  // Bytes of the start code: the zero byte and the final byte.
  localparam logic [BYTE_W-1:0] START_CODE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] START_CODE_ONE  = 8'h01;

  // Mask used to rebuild the NAL header from the FU indicator and FU header.
  localparam logic [BYTE_W-1:0] FU_IND_KEEP_MASK = 8'h81;

  // Position of the current byte inside its RTP payload.
  localparam logic [1:0] POS_HDR0    = 2'd0;
  localparam logic [1:0] POS_HDR1    = 2'd1;
  localparam logic [1:0] POS_FU_HDR  = 2'd2;
  localparam logic [1:0] POS_PAYLOAD = 2'd3;

  // Packet status codes.
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Depth of the burst queue between the parser and the output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // What one accepted input byte asks the output stage to send.
  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_BYTE,
    KIND_STATUS
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   b0;
    logic [BYTE_W-1:0]   b1;
    logic                done;
    logic                complete;
    logic [STAT_W-1:0]   status;
  } desc_t;

  // Head of the burst queue as seen by the output stage.
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_head_t;

endpackage

// File: design/hrfd_intf.sv
interface hrfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [hrfd_pkg::BYTE_W-1:0] data_byte;
  logic                      packet_last;

  modport source(output valid, output data_byte, output packet_last, input ready);
  modport sink(input valid, input data_byte, input packet_last, output ready);
endinterface

interface hrfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [hrfd_pkg::BYTE_W-1:0] out_byte;
  logic                        byte_valid;
  logic                        packet_done;
  logic                        nal_complete;
  logic [hrfd_pkg::STAT_W-1:0] status;
  logic                        last_of_run;

  modport source(output valid, output out_byte, output byte_valid, output packet_done,
                 output nal_complete, output status, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input byte_valid, input packet_done,
               input nal_complete, input status, input last_of_run, output ready);
endinterface

// File: design/hevc_rtp_fu_depacketizer.sv
// HEVC RTP depacketizer for single NAL unit packets and type-49 fragmentation
// units, producing an Annex B byte stream. One payload byte is taken per cycle
// whenever the four-entry burst queue has room; the parser works in the same
// cycle as the input beat. Each byte turns into zero, one or six output beats:
// a payload byte gives one, a NAL start gives six (start code and two header
// bytes), and the output stage sends one beat per cycle while out_ready is
// high, so a steady payload stream runs at one byte per cycle. The final beat
// of every packet carries packet_done with status and NAL completion. The
// capacity register may be written only while the block is idle; no clearing
// pass runs after reset.
module hevc_rtp_fu_depacketizer #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hrfd_pkg::CFG_W-1:0] cfg_wdata,
  hrfd_in_if.sink                    in_bus,
  hrfd_out_if.source                 out_bus
);
  import hrfd_pkg::*;

  logic    accept;
  logic    push;
  desc_t   push_desc;
  logic    pop;
  logic    full;
  q_head_t head;

  assign in_bus.ready = !full;
  assign accept       = in_bus.valid && !full;

  // Header parsing, capacity tracking and burst descriptors.
  hrfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .data_byte  (in_bus.data_byte),
    .packet_last(in_bus.packet_last),
    .push       (push),
    .push_desc  (push_desc)
  );

  // Burst queue.
  hrfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .full     (full),
    .head     (head)
  );

  // Output register and burst expansion.
  hrfd_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_byte    (out_bus.out_byte),
    .byte_valid  (out_bus.byte_valid),
    .packet_done (out_bus.packet_done),
    .nal_complete(out_bus.nal_complete),
    .status      (out_bus.status),
    .last_of_run (out_bus.last_of_run)
  );

  // A packet's report always sits on the last beat of its burst.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.packet_done |-> out_bus.last_of_run)
    else $error("packet_done on a beat that does not end its burst");

  // A finished NAL is only reported with a clean status.
  a_complete_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.nal_complete |-> out_bus.packet_done &&
    out_bus.status == STATUS_OK)
    else $error("nal_complete without packet_done and clean status");

  // A beat without a stream byte exists only to report a packet's end.
  a_empty_reports: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.byte_valid |-> out_bus.packet_done && out_bus.out_byte == '0)
    else $error("empty beat that does not report a packet end");

  // A popped entry always leaves on a beat marked last of its run.
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_bus.valid && out_bus.last_of_run)
    else $error("queue entry retired without a final beat");

endmodule

// File: design/hrfd_parser.sv
module hrfd_parser #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hrfd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        accept,
  input  logic [hrfd_pkg::BYTE_W-1:0] data_byte,
  input  logic                        packet_last,
  output logic                        push,
  output hrfd_pkg::desc_t             push_desc
);
  import hrfd_pkg::*;

  // Width that holds both the capacity register and the length counter plus one.
  localparam int CW = ((LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W) + 1;

  logic [CFG_W-1:0]       max_nal_r;
  logic [1:0]             pos_r, pos_nxt;
  logic [BYTE_W-1:0]      fhb_r, fhb_nxt;
  logic [BYTE_W-1:0]      shb_r, shb_nxt;
  logic                   frag_r, frag_nxt;
  logic                   end_r, end_nxt;
  logic                   nip_r, nip_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [STAT_W-1:0]      err_r, err_nxt;

  logic [CW-1:0] lim;
  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] cap;
  logic [CW-1:0] len_plus;
  logic          emit;

  // Effective capacity is the register clipped to what the length counter holds.
  assign lim      = {{(CW-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};
  assign cfg_ext  = {{(CW-CFG_W){1'b0}}, max_nal_r};
  assign cap      = (cfg_ext < lim) ? cfg_ext : lim;
  assign len_plus = {{(CW-LENGTH_BITS){1'b0}}, len_r} + CW'(1);

  // Per-byte parsing: next state and the burst to send for this byte.
  always_comb begin
    pos_nxt  = pos_r;
    fhb_nxt  = fhb_r;
    shb_nxt  = shb_r;
    frag_nxt = frag_r;
    end_nxt  = end_r;
    nip_nxt  = nip_r;
    len_nxt  = len_r;
    err_nxt  = err_r;
    emit     = 1'b0;
    push_desc.kind     = KIND_STATUS;
    push_desc.b0       = data_byte;
    push_desc.b1       = shb_r;
    push_desc.done     = 1'b0;
    push_desc.complete = 1'b0;
    push_desc.status   = STATUS_OK;

    case (pos_r)
      POS_HDR0: begin
        fhb_nxt  = data_byte;
        frag_nxt = (data_byte[6:1] == FU_TYPE);
        end_nxt  = 1'b0;
        err_nxt  = packet_last ? STATUS_INVALID : STATUS_OK;
      end
      POS_HDR1: begin
        shb_nxt = data_byte;
        if (!frag_r) begin
          emit           = 1'b1;
          push_desc.kind = KIND_HDR;
          push_desc.b0   = fhb_r;
          push_desc.b1   = data_byte;
        end else if (packet_last) begin
          err_nxt = STATUS_INVALID;
        end
      end
      POS_FU_HDR: begin
        if (!frag_r) begin
          emit           = 1'b1;
          push_desc.kind = KIND_BYTE;
        end else begin
          end_nxt = data_byte[6];
          if (data_byte[7]) begin
            nip_nxt = 1'b0;
            if (cap < CW'(HDR_NAL_BYTES)) begin
              err_nxt = STATUS_OVERFLOW;
            end else begin
              emit           = 1'b1;
              push_desc.kind = KIND_HDR;
              push_desc.b0   = (fhb_r & FU_IND_KEEP_MASK) | {1'b0, data_byte[5:0], 1'b0};
              push_desc.b1   = shb_r;
              len_nxt        = LENGTH_BITS'(HDR_NAL_BYTES);
              nip_nxt        = 1'b1;
            end
          end else if (!nip_r) begin
            err_nxt = STATUS_INVALID;
          end
        end
      end
      POS_PAYLOAD: begin
        if (!frag_r) begin
          emit           = 1'b1;
          push_desc.kind = KIND_BYTE;
        end else if (err_r == STATUS_OK && nip_r) begin
          if (len_plus > cap) begin
            err_nxt = STATUS_OVERFLOW;
            nip_nxt = 1'b0;
          end else begin
            len_nxt        = len_plus[LENGTH_BITS-1:0];
            emit           = 1'b1;
            push_desc.kind = KIND_BYTE;
          end
        end
      end
      default: begin
      end
    endcase

    if (pos_r != POS_PAYLOAD) begin
      pos_nxt = pos_r + 2'd1;
    end

    // The last byte of a packet reports status and closes the packet.
    push_desc.done     = packet_last;
    push_desc.status   = err_nxt;
    push_desc.complete = (err_nxt == STATUS_OK) && (!frag_nxt || end_nxt);
    if (packet_last) begin
      if (frag_nxt && push_desc.complete) begin
        nip_nxt = 1'b0;
      end
      pos_nxt  = POS_HDR0;
      err_nxt  = STATUS_OK;
      frag_nxt = 1'b0;
      end_nxt  = 1'b0;
    end
  end

  assign push = accept && (emit || packet_last);

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_nal_r <= MAX_NAL_RESET;
    end else if (cfg_we) begin
      max_nal_r <= cfg_wdata;
    end
  end

  // Parser state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HDR0;
      fhb_r  <= '0;
      shb_r  <= '0;
      frag_r <= 1'b0;
      end_r  <= 1'b0;
      nip_r  <= 1'b0;
      len_r  <= '0;
      err_r  <= STATUS_OK;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      fhb_r  <= fhb_nxt;
      shb_r  <= shb_nxt;
      frag_r <= frag_nxt;
      end_r  <= end_nxt;
      nip_r  <= nip_nxt;
      len_r  <= len_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// File: design/hrfd_queue.sv
module hrfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hrfd_pkg::desc_t  push_desc,
  input  logic             pop,
  output logic             full,
  output hrfd_pkg::q_head_t head
);
  import hrfd_pkg::*;

  desc_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.desc  = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/hrfd_emitter.sv
module hrfd_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hrfd_pkg::q_head_t            head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hrfd_pkg::BYTE_W-1:0]  out_byte,
  output logic                         byte_valid,
  output logic                         packet_done,
  output logic                         nal_complete,
  output logic [hrfd_pkg::STAT_W-1:0]  status,
  output logic                         last_of_run
);
  import hrfd_pkg::*;

  logic [2:0]        idx_r, idx_nxt;
  logic              valid_r;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              bvalid_r, bvalid_nxt;
  logic              done_r, done_nxt;
  logic              cmpl_r, cmpl_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              lor_r, lor_nxt;
  logic              load;
  logic              is_last;

  // The output register takes a new beat when empty or being drained.
  assign load = !valid_r || out_ready;
  assign pop  = load && head.valid && is_last;

  // Pick the result for the current position within the head entry's burst.
  always_comb begin
    is_last  = 1'b1;
    byte_nxt = head.desc.b0;
    case (head.desc.kind)
      KIND_HDR: begin
        is_last = (idx_r == 3'(HDR_BURST-1));
        case (idx_r)
          3'd0, 3'd1, 3'd2: byte_nxt = START_CODE_ZERO;
          3'd3:             byte_nxt = START_CODE_ONE;
          3'd4:             byte_nxt = head.desc.b0;
          default:          byte_nxt = head.desc.b1;
        endcase
      end
      KIND_BYTE: begin
        byte_nxt = head.desc.b0;
      end
      KIND_STATUS: begin
        byte_nxt = '0;
      end
      default: begin
        byte_nxt = '0;
      end
    endcase
    bvalid_nxt = (head.desc.kind != KIND_STATUS);
    done_nxt   = head.desc.done && is_last;
    cmpl_nxt   = head.desc.done && is_last && head.desc.complete;
    stat_nxt   = (head.desc.done && is_last) ? head.desc.status : STATUS_OK;
    lor_nxt    = is_last;
    idx_nxt    = is_last ? 3'd0 : idx_r + 3'd1;
  end

  // Burst position within the head entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= head.valid;
      if (head.valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      byte_r   <= byte_nxt;
      bvalid_r <= bvalid_nxt;
      done_r   <= done_nxt;
      cmpl_r   <= cmpl_nxt;
      stat_r   <= stat_nxt;
      lor_r    <= lor_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign byte_valid   = bvalid_r;
  assign packet_done  = done_r;
  assign nal_complete = cmpl_r;
  assign status       = stat_r;
  assign last_of_run  = lor_r;

endmodule
